FILE: rtl/smia_pkg.sv
`timescale 1ns / 1ps
package smia_pkg;
	localparam int STACK_DEPTH = 64;
	localparam int NUM_VARS    = 32;
	localparam int WORD_WIDTH  = 32;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int SA_W        = $clog2(STACK_DEPTH);
	localparam int VA_W        = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_UNDER = 2'd1,
		ERR_DIVZ  = 2'd2,
		ERR_OVER  = 2'd3
	} err_t;

	typedef enum logic [4:0] {
		OP_PUSHC = 5'd0,  OP_PUSHV = 5'd1,  OP_POP  = 5'd2,
		OP_LOR   = 5'd3,  OP_LAND  = 5'd4,  OP_BOR  = 5'd5,
		OP_BXOR  = 5'd6,  OP_BAND  = 5'd7,  OP_NE   = 5'd8,
		OP_EQ    = 5'd9,  OP_GT    = 5'd10, OP_GE   = 5'd11,
		OP_LT    = 5'd12, OP_LE    = 5'd13, OP_SHL  = 5'd14,
		OP_SHR   = 5'd15, OP_ADD   = 5'd16, OP_SUB  = 5'd17,
		OP_MUL   = 5'd18, OP_MOD   = 5'd19, OP_DIV  = 5'd20,
		OP_ASET  = 5'd21, OP_AADD  = 5'd22, OP_ASUB = 5'd23,
		OP_AMUL  = 5'd24, OP_AAND  = 5'd25, OP_AOR  = 5'd26,
		OP_AXOR  = 5'd27, OP_ASHL  = 5'd28, OP_ASHR = 5'd29,
		OP_ADIV  = 5'd30, OP_AMOD  = 5'd31
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_WRITE
	} state_t;

	typedef struct packed {
		logic [4:0]         op;
		logic signed [31:0] constant;
		logic [4:0]         var_index;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         error;
		logic [6:0]         depth;
	} rsp_t;

	// restoring divider chain's control
	typedef struct packed {
		logic load;
	} div_ctl_t;
endpackage

FILE: rtl/smia_div_cell.sv
`timescale 1ns / 1ps
// one restoring-division cell: holds one quotient bit and hands the
// partial remainder to its neighbor
module smia_div_cell (
	input  logic                             clk,
	input  logic                             en,
	input  logic [smia_pkg::WORD_WIDTH-1:0]  rem_in,
	input  logic                             num_bit,
	input  logic [smia_pkg::WORD_WIDTH-1:0]  divisor,
	output logic [smia_pkg::WORD_WIDTH-1:0]  rem_out,
	output logic                             q_bit
);
	import smia_pkg::*;
	logic [WORD_WIDTH:0] trial;
	logic [WORD_WIDTH:0] shifted;

	// shift in next dividend bit and try a subtract
	always_comb begin
		shifted = {rem_in, num_bit};
		trial   = shifted - {1'b0, divisor};
	end

	// hold the remainder and quotient bit of this cell
	always_ff @(posedge clk) begin
		if (en) begin
			q_bit   <= ~trial[WORD_WIDTH];
			rem_out <= trial[WORD_WIDTH] ? shifted[WORD_WIDTH-1:0]
				: trial[WORD_WIDTH-1:0];
		end
	end
endmodule

FILE: rtl/smia_divider.sv
`timescale 1ns / 1ps
// unsigned divider as a chain of cells; the active cell advances one per
// cycle along the chain
module smia_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  smia_pkg::div_ctl_t              ctl,
	input  logic [smia_pkg::WORD_WIDTH-1:0] dividend,
	input  logic [smia_pkg::WORD_WIDTH-1:0] divisor,
	output logic                            done,
	output logic [smia_pkg::WORD_WIDTH-1:0] quotient,
	output logic [smia_pkg::WORD_WIDTH-1:0] remainder
);
	import smia_pkg::*;
	logic [WORD_WIDTH-1:0] rem_w [WORD_WIDTH+1];
	logic [WORD_WIDTH-1:0] en_q;
	logic [WORD_WIDTH-1:0] num_q;
	logic [WORD_WIDTH-1:0] dsr_q;
	logic                  done_q;

	assign rem_w[0] = '0;

	for (genvar i = 0; i < WORD_WIDTH; i++) begin : g_cell
		smia_div_cell u_cell (
			.clk     (clk),
			.en      (en_q[i]),
			.rem_in  (rem_w[i]),
			.num_bit (num_q[WORD_WIDTH-1-i]),
			.divisor (dsr_q),
			.rem_out (rem_w[i+1]),
			.q_bit   (quotient[WORD_WIDTH-1-i])
		);
	end

	// hold operands for the whole division
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			num_q <= dividend;
			dsr_q <= divisor;
		end
	end

	// advance the enable token along the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q   <= '0;
			done_q <= 1'b0;
		end else begin
			if (ctl.load) en_q <= {{(WORD_WIDTH-1){1'b0}}, 1'b1};
			else          en_q <= en_q << 1;
			done_q <= en_q[WORD_WIDTH-1];
		end
	end

	assign remainder = rem_w[WORD_WIDTH];
	assign done      = done_q;

`ifndef SYNTH
	a_token_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(en_q)) else $error("divide token not one-hot");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		en_q[WORD_WIDTH-1] |=> done_q) else $error("done missing");
	a_no_reload: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> !en_q[WORD_WIDTH-1]) else $error("token skipped");
`endif
endmodule

FILE: rtl/stack_machine_integer_alu_top.sv
`timescale 1ns / 1ps
// Stack-machine integer ALU.
// Command channel: cmd (op, constant, var_index) is taken on a rising edge
// where start is high and busy is low. busy rises the cycle after a transfer
// and stays high until the result is shown.
// Result channel: rsp (value, error, depth) is valid for exactly one cycle
// while done is high; the receiver cannot stall it and must take it then.
// A command steps through the read, exec and write states, and done is
// registered from the write state; divide and modulo with a nonzero
// divisor also pass through a div state that runs a chain of 32 restoring
// divide cells, one cell active per cycle. A command may be given in the
// cycle done is high (busy is low then), but not while one is in flight.
// Operand stack is a 64-entry memory with one read port, read registered;
// the variable store is 32 flip-flop words with valid bits, reading zero
// until first written.
// Reset (arst_n low) empties the stack, clears all variable valid bits and
// returns the sequencer to idle. No clearing pass is needed.
module stack_machine_integer_alu_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  smia_pkg::cmd_t cmd,
	output logic           done,
	output smia_pkg::rsp_t rsp
);
	import smia_pkg::*;
	localparam int W = WORD_WIDTH;

	logic [W-1:0]    stk_mem [STACK_DEPTH];
	logic [W-1:0]    var_q [NUM_VARS];
	logic [NUM_VARS-1:0] vvld_q;
	logic [SP_W-1:0] sp_q;
	state_t          st_q, st_d;
	cmd_t            cmd_q;
	logic [W-1:0]    a_q, res_q;
	logic [SA_W-1:0] rd_addr;
	logic [W-1:0]    rd_data_q;
	err_t            err_q;
	logic [VA_W-1:0] vi;
	logic [W-1:0]    vval;
	logic            is_bin, is_asg, need2, isdiv;
	logic [4:0]      code;
	logic [W-1:0]    alu_a, alu_b, alu_y;
	div_ctl_t        dctl;
	logic            ddone;
	logic [W-1:0]    dq, dr, ma, mb;
	logic            na_q, nb_q, wrem_q;
	logic            done_q;
	logic [W-1:0]    mul_p;

	assign vi   = VA_W'(cmd_q.var_index % NUM_VARS);
	assign vval = vvld_q[vi] ? var_q[vi] : '0;
	assign is_bin = (cmd_q.op >= OP_LOR) && (cmd_q.op <= OP_DIV);
	assign is_asg = cmd_q.op >= OP_ASET;
	assign need2  = is_bin;

	// map assign ops onto binary alu codes (op - 3 numbering)
	always_comb begin
		unique case (cmd_q.op)
			OP_AADD: code = 5'd13;
			OP_ASUB: code = 5'd14;
			OP_AMUL: code = 5'd15;
			OP_AAND: code = 5'd4;
			OP_AOR:  code = 5'd2;
			OP_AXOR: code = 5'd3;
			OP_ASHL: code = 5'd11;
			OP_ASHR: code = 5'd12;
			OP_ADIV: code = 5'd17;
			OP_AMOD: code = 5'd16;
			default: code = 5'(cmd_q.op - OP_LOR);
		endcase
	end
	assign isdiv = (is_bin || (is_asg && cmd_q.op != OP_ASET)) && code >= 5'd16;
	assign alu_a = is_asg ? vval : a_q;
	// top operand is on the read port during the exec step
	assign alu_b = rd_data_q;
	assign mul_p = alu_a * alu_b;

	// combinational ops, all but divide and modulo
	always_comb begin
		case (code)
			5'd0:  alu_y = W'((alu_a != 0) || (alu_b != 0));
			5'd1:  alu_y = W'((alu_a != 0) && (alu_b != 0));
			5'd2:  alu_y = alu_a | alu_b;
			5'd3:  alu_y = alu_a ^ alu_b;
			5'd4:  alu_y = alu_a & alu_b;
			5'd5:  alu_y = W'(alu_a != alu_b);
			5'd6:  alu_y = W'(alu_a == alu_b);
			5'd7:  alu_y = W'($signed(alu_a) > $signed(alu_b));
			5'd8:  alu_y = W'($signed(alu_a) >= $signed(alu_b));
			5'd9:  alu_y = W'($signed(alu_a) < $signed(alu_b));
			5'd10: alu_y = W'($signed(alu_a) <= $signed(alu_b));
			5'd11: alu_y = (alu_b >= W) ? '0 : alu_a << alu_b;
			5'd12: alu_y = (alu_b >= W) ? {W{alu_a[W-1]}}
				: W'($signed(alu_a) >>> alu_b);
			5'd13: alu_y = alu_a + alu_b;
			5'd14: alu_y = alu_a - alu_b;
			5'd15: alu_y = mul_p;
			default: alu_y = '0;
		endcase
	end

	assign ma = alu_a[W-1] ? W'(-alu_a) : alu_a;
	assign mb = alu_b[W-1] ? W'(-alu_b) : alu_b;

	// stack read address: next-below while idle, top from the read step on
	assign rd_addr = (st_q == ST_IDLE) ? SA_W'(sp_q - 2) : SA_W'(sp_q - 1);

	smia_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (dctl),
		.dividend  (ma),
		.divisor   (mb),
		.done      (ddone),
		.quotient  (dq),
		.remainder (dr)
	);

	// next state
	always_comb begin
		st_d = st_q;
		dctl = '0;
		unique case (st_q)
			ST_IDLE:  if (start) st_d = ST_READ;
			ST_READ:  st_d = ST_EXEC;
			ST_EXEC: begin
				if (err_q == ERR_OK && isdiv && rd_data_q != '0) begin
					dctl.load = 1'b1;
					st_d = ST_DIV;
				end else st_d = ST_WRITE;
			end
			ST_DIV:   if (ddone) st_d = ST_WRITE;
			ST_WRITE: st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// stack memory read port, registered
	always_ff @(posedge clk) begin
		rd_data_q <= stk_mem[rd_addr];
	end

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			sp_q   <= '0;
			vvld_q <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= 1'b0;
			if (st_q == ST_WRITE) begin
				done_q <= 1'b1;
				if (err_q == ERR_OK) begin
					if (cmd_q.op <= OP_PUSHV) sp_q <= sp_q + 1'b1;
					else if (cmd_q.op == OP_POP || is_bin) sp_q <= sp_q - 1'b1;
					if (is_asg) vvld_q[vi] <= 1'b1;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start) cmd_q <= cmd;
		// read of sp-2 issued in IDLE lands here; sp-1 read issued now
		if (st_q == ST_READ) begin
			a_q <= rd_data_q;
			if (cmd_q.op <= OP_PUSHV) begin
				err_q <= (sp_q >= SP_W'(STACK_DEPTH)) ? ERR_OVER : ERR_OK;
			end else if (sp_q < (need2 ? SP_W'(2) : SP_W'(1))) begin
				err_q <= ERR_UNDER;
			end else begin
				err_q <= ERR_OK;
			end
		end
		// top operand lands here: flag a zero divisor and pick the result
		if (st_q == ST_EXEC) begin
			if (err_q == ERR_OK && isdiv && rd_data_q == '0) err_q <= ERR_DIVZ;
			if (cmd_q.op == OP_PUSHC) res_q <= cmd_q.constant;
			else if (cmd_q.op == OP_PUSHV) res_q <= vval;
			else if (cmd_q.op == OP_POP || cmd_q.op == OP_ASET) res_q <= rd_data_q;
			else res_q <= alu_y;
		end
		if (st_q == ST_DIV && ddone) begin
			res_q <= wrem_q ? (na_q ? W'(-dr) : dr)
				: ((na_q ^ nb_q) ? W'(-dq) : dq);
		end
		if (dctl.load) begin
			na_q   <= alu_a[W-1];
			nb_q   <= alu_b[W-1];
			wrem_q <= (code == 5'd16);
		end
		if (st_q == ST_WRITE && err_q == ERR_OK) begin
			if (cmd_q.op <= OP_PUSHV)
				stk_mem[SA_W'(sp_q)] <= res_q;
			else if (is_bin)
				stk_mem[SA_W'(sp_q - 2)] <= res_q;
			else if (is_asg)
				stk_mem[SA_W'(sp_q - 1)] <= res_q;
			if (is_asg) var_q[vi] <= res_q;
		end
		if (st_q == ST_WRITE) begin
			rsp.error <= err_q;
			rsp.value <= (err_q == ERR_OK) ? res_q : '0;
			if (err_q == ERR_OK && (cmd_q.op <= OP_PUSHV))
				rsp.depth <= 7'(sp_q + 1'b1);
			else if (err_q == ERR_OK && (cmd_q.op == OP_POP || is_bin))
				rsp.depth <= 7'(sp_q - 1'b1);
			else
				rsp.depth <= 7'(sp_q);
		end
	end

	assign busy = (st_q != ST_IDLE);
	assign done = done_q;
`ifndef SYNTH
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH)) else $error("stack pointer out of range");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done longer than one cycle");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy) else $error("done while busy");
`endif
endmodule

FILE: sim/tb_stack_machine_integer_alu_top.sv
`timescale 1ns / 1ps
module tb_stack_machine_integer_alu_top;
	import smia_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	rsp_t rsp;

	stack_machine_integer_alu_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .rsp(rsp)
	);

	// predictor state
	logic [31:0] op_stack [STACK_DEPTH];
	int unsigned sp;
	logic [31:0] vars [NUM_VARS];
	rsp_t expected_q [$];
	int err_count;
	int sent;

	// directed rows: fixed expectation used only where check_fixed is set
	typedef struct {
		op_t op;
		logic [31:0] constant;
		logic [4:0] var_index;
		bit check_fixed;
		rsp_t fixed;
	} row_t;
	row_t rows [$];

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("tb_stack_machine_integer_alu_top: done, errors");
		$finish;
	end

	task automatic report(input string what);
		$display("MISMATCH: %s", what);
		err_count++;
	endtask

	function automatic logic signed_lt(logic [31:0] a, logic [31:0] b);
		return $signed(a) < $signed(b);
	endfunction

	function automatic logic [31:0] signed_div(logic [31:0] a, logic [31:0] b, bit want_rem);
		logic [31:0] ma, mb, q, r;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		r = ma % mb;
		if (want_rem) return a[31] ? -r : r;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	// compute one binary operator result, op given as its binary op_t code
	function automatic logic [31:0] apply_binop(op_t o, logic [31:0] a, logic [31:0] b);
		case (o)
			OP_LOR: return {31'b0, (a != 0) || (b != 0)};
			OP_LAND: return {31'b0, (a != 0) && (b != 0)};
			OP_BOR: return a | b;
			OP_BXOR: return a ^ b;
			OP_BAND: return a & b;
			OP_NE: return {31'b0, a != b};
			OP_EQ: return {31'b0, a == b};
			OP_GT: return {31'b0, signed_lt(b, a)};
			OP_GE: return {31'b0, !signed_lt(a, b)};
			OP_LT: return {31'b0, signed_lt(a, b)};
			OP_LE: return {31'b0, !signed_lt(b, a)};
			OP_SHL: return (b >= 32) ? 32'd0 : a << b[4:0];
			OP_SHR: return (b >= 32) ? {32{a[31]}} : $unsigned($signed(a) >>> b[4:0]);
			OP_ADD: return a + b;
			OP_SUB: return a - b;
			OP_MUL: return a * b;
			OP_MOD: return signed_div(a, b, 1);
			default: return signed_div(a, b, 0);
		endcase
	endfunction

	// map an assign op to its binary op
	function automatic op_t assign_to_binop(op_t o);
		case (o)
			OP_AADD: return OP_ADD;
			OP_ASUB: return OP_SUB;
			OP_AMUL: return OP_MUL;
			OP_AAND: return OP_BAND;
			OP_AOR: return OP_BOR;
			OP_AXOR: return OP_BXOR;
			OP_ASHL: return OP_SHL;
			OP_ASHR: return OP_SHR;
			OP_ADIV: return OP_DIV;
			default: return OP_MOD;
		endcase
	endfunction

	// advance the stack machine by one instruction and return its result
	function automatic rsp_t execute_instr(cmd_t c);
		rsp_t r;
		op_t o;
		logic [31:0] a, b, v;
		err_t e;
		o = op_t'(c.op);
		e = ERR_OK;
		v = '0;
		if (o == OP_PUSHC || o == OP_PUSHV) begin
			if (sp >= STACK_DEPTH) e = ERR_OVER;
			else begin
				v = (o == OP_PUSHC) ? c.constant : vars[c.var_index];
				op_stack[sp] = v;
				sp++;
			end
		end else if (o == OP_POP) begin
			if (sp < 1) e = ERR_UNDER;
			else begin
				sp--;
				v = op_stack[sp];
			end
		end else if (o <= OP_DIV) begin
			if (sp < 2) e = ERR_UNDER;
			else begin
				a = op_stack[sp - 2];
				b = op_stack[sp - 1];
				if ((o == OP_MOD || o == OP_DIV) && b == 0) e = ERR_DIVZ;
				else begin
					v = apply_binop(o, a, b);
					sp--;
					op_stack[sp - 1] = v;
				end
			end
		end else begin
			if (sp < 1) e = ERR_UNDER;
			else begin
				b = op_stack[sp - 1];
				if ((o == OP_ADIV || o == OP_AMOD) && b == 0) e = ERR_DIVZ;
				else begin
					v = (o == OP_ASET) ? b : apply_binop(assign_to_binop(o), vars[c.var_index], b);
					vars[c.var_index] = v;
					op_stack[sp - 1] = v;
				end
			end
		end
		r.value = (e == ERR_OK) ? v : '0;
		r.error = e;
		r.depth = sp[6:0];
		return r;
	endfunction

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n && done) begin
			if (expected_q.size() == 0) report("result with no expectation");
			else begin
				exp_r = expected_q.pop_front();
				if (rsp.value !== exp_r.value)
					report($sformatf("value %h exp %h", rsp.value, exp_r.value));
				if (rsp.error !== exp_r.error)
					report($sformatf("error %0d exp %0d", rsp.error, exp_r.error));
				if (rsp.depth !== exp_r.depth)
					report($sformatf("depth %0d exp %0d", rsp.depth, exp_r.depth));
			end
		end
	end

	function automatic rsp_t mk_rsp(logic [31:0] v, err_t e, int d);
		rsp_t r;
		r.value = v;
		r.error = e;
		r.depth = d[6:0];
		return r;
	endfunction

	function automatic row_t mk_row(op_t o, logic [31:0] k, logic [4:0] vi, bit f, rsp_t fx);
		row_t r;
		r.op = o;
		r.constant = k;
		r.var_index = vi;
		r.check_fixed = f;
		r.fixed = fx;
		return r;
	endfunction

	// hand one instruction over and record its expectation at the transfer;
	// start stays high between back-to-back items
	task automatic send_instr(cmd_t c, bit gaps, bit check_fixed, rsp_t fixed);
		rsp_t p;
		if (gaps && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		p = execute_instr(c);
		if (check_fixed && p !== fixed)
			report($sformatf("directed row %0d: fixed expectation disagrees", sent));
		expected_q.push_back(check_fixed ? fixed : p);
		sent++;
		@(negedge clk);
	endtask

	function automatic cmd_t rand_cmd(int unsigned depth_now);
		cmd_t c;
		int unsigned pick;
		c.var_index = 5'($urandom_range(0, 31));
		pick = $urandom_range(0, 9);
		case ($urandom_range(0, 3))
			0: c.constant = $urandom;
			1: c.constant = $urandom_range(0, 40) - 20;
			2: c.constant = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'(pick == 0 ? 0 : '1)};
			default: c.constant = $urandom_range(0, 70);
		endcase
		// keep the stack mostly in a working range, but hit both ends
		if (depth_now < 3 && pick < 7) c.op = 5'($urandom_range(0, 1));
		else if (depth_now > 60 && pick < 6) c.op = 5'($urandom_range(2, 31));
		else if (pick < 4) c.op = 5'($urandom_range(0, 1));
		else c.op = 5'($urandom_range(2, 31));
		return c;
	endfunction

	initial begin
		cmd_t c;
		rsp_t none;
		int unsigned burst_left;
		bit gaps;
		err_count = 0;
		sent = 0;
		sp = 0;
		none = '0;
		foreach (vars[i]) vars[i] = '0;
		foreach (op_stack[i]) op_stack[i] = '0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		rows.push_back(mk_row(OP_POP, 0, 0, 1, mk_rsp(0, ERR_UNDER, 0)));
		rows.push_back(mk_row(OP_ASET, 0, 0, 1, mk_rsp(0, ERR_UNDER, 0)));
		rows.push_back(mk_row(OP_PUSHV, 0, 5'd31, 1, mk_rsp(0, ERR_OK, 1)));
		rows.push_back(mk_row(OP_ADD, 0, 0, 1, mk_rsp(0, ERR_UNDER, 1)));
		rows.push_back(mk_row(OP_PUSHC, 32'h8000_0000, 0, 1, mk_rsp(32'h8000_0000, ERR_OK, 2)));
		rows.push_back(mk_row(OP_PUSHC, 32'hFFFF_FFFF, 0, 1, mk_rsp(32'hFFFF_FFFF, ERR_OK, 3)));
		rows.push_back(mk_row(OP_DIV, 0, 0, 1, mk_rsp(32'h8000_0000, ERR_OK, 2)));
		rows.push_back(mk_row(OP_PUSHC, 32'hFFFF_FFFF, 0, 0, none));
		rows.push_back(mk_row(OP_MOD, 0, 0, 1, mk_rsp(0, ERR_OK, 2)));
		rows.push_back(mk_row(OP_DIV, 0, 0, 1, mk_rsp(0, ERR_DIVZ, 2)));
		rows.push_back(mk_row(OP_AMOD, 0, 5'd3, 1, mk_rsp(0, ERR_DIVZ, 2)));
		rows.push_back(mk_row(OP_PUSHC, 32'h7FFF_FFFF, 0, 0, none));
		rows.push_back(mk_row(OP_ASET, 0, 5'd31, 1, mk_rsp(32'h7FFF_FFFF, ERR_OK, 3)));
		rows.push_back(mk_row(OP_PUSHC, 32'd40, 0, 0, none));
		rows.push_back(mk_row(OP_SHR, 0, 0, 0, none));
		rows.push_back(mk_row(OP_PUSHC, 32'd32, 0, 0, none));
		rows.push_back(mk_row(OP_SHL, 0, 0, 0, none));
		rows.push_back(mk_row(OP_PUSHC, -32'sd7, 0, 0, none));
		rows.push_back(mk_row(OP_PUSHC, 32'd2, 0, 0, none));
		rows.push_back(mk_row(OP_MOD, 0, 0, 0, none));
		rows.push_back(mk_row(OP_PUSHV, 0, 5'd31, 0, none));
		rows.push_back(mk_row(OP_AADD, 0, 5'd31, 0, none));
		foreach (rows[i]) begin
			c.op = rows[i].op;
			c.constant = rows[i].constant;
			c.var_index = rows[i].var_index;
			send_instr(c, 0, rows[i].check_fixed, rows[i].fixed);
		end
		// every op once
		for (int o = 0; o < 32; o++) begin
			c.op = o[4:0];
			c.constant = $urandom;
			c.var_index = 5'($urandom_range(0, 31));
			send_instr(c, 0, 0, none);
		end
		// fill to overflow, then drain with pops and random binary and assign ops
		for (int i = 0; i < STACK_DEPTH + 2; i++) begin
			c.op = OP_PUSHC;
			c.constant = $urandom;
			c.var_index = '0;
			send_instr(c, 1, 0, none);
		end
		// hold off until every outstanding result has arrived
		start <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		for (int i = 0; i < STACK_DEPTH + 2; i++) begin
			c = rand_cmd(sp);
			c.op = (i % 3 == 0) ? 5'(OP_POP) : 5'($urandom_range(3, 31));
			send_instr(c, 1, 0, none);
		end

		// random part; the last stretch runs without gaps
		for (int i = 0; i < 864; i++) begin
			gaps = (i < 740) && ($urandom_range(0, 3) != 0);
			send_instr(rand_cmd(sp), gaps, 0, none);
		end

		start <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (err_count == 0 && expected_q.size() == 0)
			$display("tb_stack_machine_integer_alu_top: done, clean");
		else
			$display("tb_stack_machine_integer_alu_top: done, errors");
		$finish;
	end
endmodule
